// ----- design/s2e_pkg.sv -----
`default_nettype none

package s2e_pkg;

  // Per-stage control that travels alongside the data of one beat
  typedef struct packed {
    logic valid;
    logic last;
  } s2e_ctl_t;

endpackage

`default_nettype wire

// ----- design/s2e_if.sv -----
`default_nettype none

// Tensor input channel: one pixel's xx, xy, yy entries per beat
interface s2e_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] tensor_xx;
  logic signed [DATA_WIDTH-1:0] tensor_xy;
  logic signed [DATA_WIDTH-1:0] tensor_yy;
  logic                         last_in;

  modport source (output valid, tensor_xx, tensor_xy, tensor_yy, last_in, input ready);
  modport sink   (input valid, tensor_xx, tensor_xy, tensor_yy, last_in, output ready);
endinterface

// Eigenvalue output channel: small/large eigenvalue per beat
interface s2e_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH+1:0] eig_small;
  logic signed [DATA_WIDTH+1:0] eig_big;
  logic                         last_out;

  modport source (output valid, eig_small, eig_big, last_out, input ready);
  modport sink   (input valid, eig_small, eig_big, last_out, output ready);
endinterface

`default_nettype wire

// ----- design/s2e_front.sv -----
`default_nettype none

// Front end: trace, magnitudes, split squaring and the radicand sum.
// Four register stages, each with its own valid bit.
module s2e_front
  import s2e_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  s2e_in_if.sink                       in_i,
  output s2e_ctl_t                     ctl_o,
  input  wire logic                    ready_i,
  output logic signed [DATA_WIDTH:0]   t_o,
  output logic [2*DATA_WIDTH+1:0]      rad_o
);

  localparam int W  = DATA_WIDTH;
  localparam int MW = W + 1;          // magnitude width
  localparam int H  = (MW + 1) / 2;   // low half width
  localparam int HW = MW - H;         // high half width
  localparam int RW = 2 * MW;         // radicand width

  // stage 1: trace, |x - z|, 2|y|
  s2e_ctl_t               ctl1_q;
  logic signed [W:0]      t1_q;
  logic [MW-1:0]          dmag1_q, ymag1_q;
  // stage 2: partial products
  s2e_ctl_t               ctl2_q;
  logic signed [W:0]      t2_q;
  logic [2*HW-1:0]        dhh2_q, yhh2_q;
  logic [MW-1:0]          dhl2_q, yhl2_q;
  logic [2*H-1:0]         dll2_q, yll2_q;
  // stage 3: the two squares
  s2e_ctl_t               ctl3_q;
  logic signed [W:0]      t3_q;
  logic [RW-1:0]          dsq3_q, ysq3_q;
  // stage 4: radicand
  s2e_ctl_t               ctl4_q;
  logic signed [W:0]      t4_q;
  logic [RW-1:0]          rad4_q;

  logic rdy1, rdy2, rdy3, rdy4;

  // combinational terms
  logic signed [W:0]      diff_d, trace_d;
  logic [W-1:0]           yabs_d;
  logic [MW-1:0]          dmag_d, ymag_d;
  logic [HW-1:0]          dh, yh;
  logic [H-1:0]           dl, yl;

  // ready chain: a stage takes a beat when empty or when it drains
  assign rdy4     = !ctl4_q.valid || ready_i;
  assign rdy3     = !ctl3_q.valid || rdy4;
  assign rdy2     = !ctl2_q.valid || rdy3;
  assign rdy1     = !ctl1_q.valid || rdy2;
  assign in_i.ready = rdy1;

  always_comb begin
    trace_d = {in_i.tensor_xx[W-1], in_i.tensor_xx} + {in_i.tensor_yy[W-1], in_i.tensor_yy};
    diff_d  = {in_i.tensor_xx[W-1], in_i.tensor_xx} - {in_i.tensor_yy[W-1], in_i.tensor_yy};
    dmag_d  = diff_d[W] ? MW'(-diff_d) : MW'(diff_d);
    yabs_d  = in_i.tensor_xy[W-1] ? W'(-in_i.tensor_xy) : W'(in_i.tensor_xy);
    ymag_d  = {yabs_d, 1'b0};
  end

  assign dh = dmag1_q[MW-1:H];
  assign dl = dmag1_q[H-1:0];
  assign yh = ymag1_q[MW-1:H];
  assign yl = ymag1_q[H-1:0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      if (rdy1) ctl1_q <= '{valid: in_i.valid, last: in_i.last_in};
      if (rdy2) ctl2_q <= ctl1_q;
      if (rdy3) ctl3_q <= ctl2_q;
      if (rdy4) ctl4_q <= ctl3_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      t1_q    <= trace_d;
      dmag1_q <= dmag_d;
      ymag1_q <= ymag_d;
    end
    if (rdy2 && ctl1_q.valid) begin
      t2_q   <= t1_q;
      dhh2_q <= dh * dh;
      dhl2_q <= dh * dl;
      dll2_q <= dl * dl;
      yhh2_q <= yh * yh;
      yhl2_q <= yh * yl;
      yll2_q <= yl * yl;
    end
    if (rdy3 && ctl2_q.valid) begin
      t3_q   <= t2_q;
      dsq3_q <= (RW'(dhh2_q) << (2 * H)) + (RW'(dhl2_q) << (H + 1)) + RW'(dll2_q);
      ysq3_q <= (RW'(yhh2_q) << (2 * H)) + (RW'(yhl2_q) << (H + 1)) + RW'(yll2_q);
    end
    if (rdy4 && ctl3_q.valid) begin
      t4_q   <= t3_q;
      rad4_q <= dsq3_q + ysq3_q;
    end
  end

  assign ctl_o = ctl4_q;
  assign t_o   = t4_q;
  assign rad_o = rad4_q;

endmodule

`default_nettype wire

// ----- design/s2e_root_step.sv -----
`default_nettype none

// One digit of the restoring square root: brings in two radicand bits,
// decides one root bit and registers the result.
module s2e_root_step
  import s2e_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire s2e_ctl_t                  ctl_i,
  output logic                           ready_o,
  input  wire logic signed [DATA_WIDTH:0] t_i,
  input  wire logic [DATA_WIDTH+3:0]     rem_i,
  input  wire logic [DATA_WIDTH:0]       root_i,
  input  wire logic [2*DATA_WIDTH+1:0]   rad_i,
  output s2e_ctl_t                       ctl_o,
  input  wire logic                      ready_i,
  output logic signed [DATA_WIDTH:0]     t_o,
  output logic [DATA_WIDTH+3:0]          rem_o,
  output logic [DATA_WIDTH:0]            root_o,
  output logic [2*DATA_WIDTH+1:0]        rad_o
);

  localparam int N   = DATA_WIDTH + 1;  // root bits
  localparam int RW  = 2 * N;           // radicand bits
  localparam int RMW = N + 3;           // remainder bits

  s2e_ctl_t          ctl_q;
  logic signed [N-1:0] t_q;
  logic [RMW-1:0]    rem_q;
  logic [N-1:0]      root_q;
  logic [RW-1:0]     rad_q;

  logic [RMW-1:0]    rem_sh, trial;
  logic [RMW-1:0]    rem_d;
  logic [N-1:0]      root_d;
  logic              fits;

  assign ready_o = !ctl_q.valid || ready_i;

  // trial subtract of (4*root + 1)
  always_comb begin
    rem_sh = {rem_i[RMW-3:0], rad_i[RW-1:RW-2]};
    trial  = {1'b0, root_i, 2'b01};
    fits   = (rem_sh >= trial);
    rem_d  = fits ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[N-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      t_q    <= t_i;
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= {rad_i[RW-3:0], 2'b00};
    end
  end

  assign ctl_o  = ctl_q;
  assign t_o    = t_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

`default_nettype wire

// ----- design/s2e_back.sv -----
`default_nettype none

// Output stage: half trace minus/plus half root, floored, into the
// output register.
module s2e_back
  import s2e_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire s2e_ctl_t                   ctl_i,
  output logic                            ready_o,
  input  wire logic signed [DATA_WIDTH:0] t_i,
  input  wire logic [DATA_WIDTH:0]        root_i,
  s2e_out_if.source                       out_o
);

  localparam int W = DATA_WIDTH;

  logic                 vld_q;
  logic                 last_q;
  logic signed [W+1:0]  small_q, big_q;
  logic signed [W+2:0]  sum_big, sum_small;

  assign ready_o = !vld_q || out_o.ready;

  // arithmetic shift of the sum floors the halving
  always_comb begin
    sum_big   = $signed({{2{t_i[W]}}, t_i}) + $signed({2'b00, root_i});
    sum_small = $signed({{2{t_i[W]}}, t_i}) - $signed({2'b00, root_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      big_q   <= sum_big[W+2:1];
      small_q <= sum_small[W+2:1];
      last_q  <= ctl_i.last;
    end
  end

  assign out_o.valid     = vld_q;
  assign out_o.eig_small = small_q;
  assign out_o.eig_big   = big_q;
  assign out_o.last_out  = last_q;

endmodule

`default_nettype wire

// ----- design/sym2x2_eigenvalues_unit.sv -----
`default_nettype none

// Eigenvalues of a symmetric 2x2 tensor, one pixel per beat. Inputs xx, xy, yy are
// signed fixed point (Q15.16 at the default width); outputs are two bits wider and
// carry the same fraction bits, so they never overflow. eig_big/eig_small are
// floor((T +/- S)/2) with T = xx + yy and S = floor(sqrt((xx-yy)^2 + 4*xy^2)); the
// fraction position cancels out, so any Q format works. The pipeline accepts one
// beat every cycle while ready is high. The pipe is made of four front stages
// for trace, split squaring and the radicand sum, one stage per root bit of the
// restoring square root (DATA_WIDTH+1), and the output register. Every stage
// has its own valid bit and empty stages absorb stalls, so ready deasserts only
// when the whole pipe is full. last_in is passed through to last_out unchanged.
module sym2x2_eigenvalues_unit
  import s2e_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  s2e_in_if.sink    in_i,
  s2e_out_if.source out_o
);

  localparam int N   = DATA_WIDTH + 1;
  localparam int RW  = 2 * N;
  localparam int RMW = N + 3;

  // taps between root steps; index 0 is the front end output
  s2e_ctl_t            ctl_s   [0:N];
  logic                rdy_s   [0:N];
  logic signed [N-1:0] t_s     [0:N];
  logic [RMW-1:0]      rem_s   [0:N];
  logic [N-1:0]        root_s  [0:N];
  logic [RW-1:0]       rad_s   [0:N];

  s2e_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctl_o  (ctl_s[0]),
    .ready_i(rdy_s[0]),
    .t_o    (t_s[0]),
    .rad_o  (rad_s[0])
  );

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  // square root, one bit per stage
  for (genvar k = 0; k < N; k++) begin : g_root
    s2e_root_step #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[k]),
      .ready_o(rdy_s[k]),
      .t_i    (t_s[k]),
      .rem_i  (rem_s[k]),
      .root_i (root_s[k]),
      .rad_i  (rad_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .ready_i(rdy_s[k+1]),
      .t_o    (t_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .root_o (root_s[k+1]),
      .rad_o  (rad_s[k+1])
    );
  end

  s2e_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_s[N]),
    .ready_o(rdy_s[N]),
    .t_i    (t_s[N]),
    .root_i (root_s[N]),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ----- design/s2e_checker.sv -----
`default_nettype none

// Port-level checks for the eigenvalue unit
module s2e_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic signed [DATA_WIDTH+1:0] eig_small_i,
  input wire logic signed [DATA_WIDTH+1:0] eig_big_i,
  input wire logic                         last_out_i
);

  // eigenvalues come out ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (eig_small_i <= eig_big_i))
    else $error("eig_small above eig_big");

  // with the output register empty every stage drains, so input is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

  // nothing comes out during reset
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output beat during reset");

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(eig_small_i) && $stable(eig_big_i) && $stable(last_out_i)))
    else $error("stalled output beat changed");

endmodule

bind sym2x2_eigenvalues_unit s2e_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_s2e_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .eig_small_i(out_o.eig_small),
  .eig_big_i  (out_o.eig_big),
  .last_out_i (out_o.last_out)
);

`default_nettype wire
